// ===== rtl/ray_sphere_intersection_macros.svh =====
// Assertion helpers shared by the RTL of the ray and sphere intersection block.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef RAY_SPHERE_INTERSECTION_MACROS_SVH
`define RAY_SPHERE_INTERSECTION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsi_pkg.sv =====
`timescale 1ns / 1ps

package rsi_pkg;

    // Coordinate format: signed fixed point, CW bits with FB fraction bits.
    localparam int CW   = 32;
    localparam int FB   = 16;

    // Derived widths of the intermediate values.
    localparam int OCW  = CW + 1;          // origin minus center
    localparam int AW   = 2 * CW + 2;      // a = dir.dir
    localparam int BW   = 2 * CW + 3;      // b = 2 (oc.dir)
    localparam int CCW  = 2 * CW + 4;      // c = oc.oc - r^2
    localparam int SPL  = CW + 2;          // split point of the wide products
    localparam int DW   = 4 * CW + 6;      // discriminant
    localparam int RW   = DW / 2;          // square root of the discriminant
    localparam int REMW = RW + 3;          // square root partial remainder
    localparam int NUMW = RW + 2 + FB;     // numerator of the root
    localparam int QW   = CW + 1;          // quotient bits kept before saturation
    localparam int DENW = AW + 1;          // denominator 2a
    localparam int DIVW = (DENW + QW > NUMW) ? DENW + QW : NUMW;

    // Saturation limits as quotient magnitudes.
    localparam logic [QW-1:0] Q_MAXPOS = QW'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic [QW-1:0] Q_MINMAG = QW'(64'd1 << (CW - 1));

    // Result status codes.
    localparam int STW = 2;
    localparam logic [STW-1:0] ST_HIT   = 2'd0;
    localparam logic [STW-1:0] ST_MISS  = 2'd1;
    localparam logic [STW-1:0] ST_DEGEN = 2'd2;

endpackage

// ===== rtl/ray_sphere_intersection.sv =====
// Throughput: one item per cycle while the output is not stalled. The square root
// takes one stage per root bit and the divider one stage per quotient bit, so
// neither unit is shared between items.
// A stalled output freezes every stage at once, so nothing is dropped or repeated.
// Reset (synchronous, active low) clears every stage valid bit; data is not reset.
`timescale 1ns / 1ps
`include "ray_sphere_intersection_macros.svh"

module ray_sphere_intersection (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [rsi_pkg::CW-1:0]    i_origin_x,
    input  logic signed [rsi_pkg::CW-1:0]    i_origin_y,
    input  logic signed [rsi_pkg::CW-1:0]    i_origin_z,
    input  logic signed [rsi_pkg::CW-1:0]    i_dir_x,
    input  logic signed [rsi_pkg::CW-1:0]    i_dir_y,
    input  logic signed [rsi_pkg::CW-1:0]    i_dir_z,
    input  logic signed [rsi_pkg::CW-1:0]    i_center_x,
    input  logic signed [rsi_pkg::CW-1:0]    i_center_y,
    input  logic signed [rsi_pkg::CW-1:0]    i_center_z,
    input  logic signed [rsi_pkg::CW-1:0]    i_sphere_radius,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic        [rsi_pkg::STW-1:0]   o_status,
    output logic signed [rsi_pkg::CW-1:0]    o_hit_distance
);

    localparam int CW   = rsi_pkg::CW;
    localparam int OCW  = rsi_pkg::OCW;
    localparam int AW   = rsi_pkg::AW;
    localparam int BW   = rsi_pkg::BW;
    localparam int CCW  = rsi_pkg::CCW;
    localparam int SPL  = rsi_pkg::SPL;
    localparam int DW   = rsi_pkg::DW;
    localparam int RW   = rsi_pkg::RW;
    localparam int REMW = rsi_pkg::REMW;
    localparam int NUMW = rsi_pkg::NUMW;
    localparam int QW   = rsi_pkg::QW;
    localparam int DENW = rsi_pkg::DENW;
    localparam int DIVW = rsi_pkg::DIVW;
    localparam int STW  = rsi_pkg::STW;

    // The whole pipeline moves together. It advances whenever the output register
    // is empty or its item is being taken, so a new item can enter in the same
    // cycle that a finished result is handed over.
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    logic signed [CW-1:0] w_org [3];
    logic signed [CW-1:0] w_ctr [3];
    logic signed [CW-1:0] w_dir [3];

    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_ctr[0] = i_center_x;
    assign w_ctr[1] = i_center_y;
    assign w_ctr[2] = i_center_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    // ------------------------------------------------------------------------
    // Stage 1: offset of the ray origin from the sphere center.
    // ------------------------------------------------------------------------
    logic                  r1_valid;
    logic signed [OCW-1:0] r1_oc  [3];
    logic signed [CW-1:0]  r1_dir [3];
    logic signed [CW-1:0]  r1_rad;
    logic signed [OCW-1:0] n1_oc  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n1_oc[k] = {w_org[k][CW-1], w_org[k]} - {w_ctr[k][CW-1], w_ctr[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_oc  <= n1_oc;
            r1_dir <= w_dir;
            r1_rad <= i_sphere_radius;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: the ten element products of the three dot products and r^2.
    // ------------------------------------------------------------------------
    logic                        r2_valid;
    logic signed [2*CW-1:0]      r2_dd [3];
    logic signed [OCW+CW-1:0]    r2_od [3];
    logic signed [2*OCW-1:0]     r2_oo [3];
    logic signed [2*CW-1:0]      r2_rr;
    logic signed [2*CW-1:0]      n2_dd [3];
    logic signed [OCW+CW-1:0]    n2_od [3];
    logic signed [2*OCW-1:0]     n2_oo [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n2_dd[k] = r1_dir[k] * r1_dir[k];
            n2_od[k] = r1_oc[k] * r1_dir[k];
            n2_oo[k] = r1_oc[k] * r1_oc[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dd <= n2_dd;
            r2_od <= n2_od;
            r2_oo <= n2_oo;
            r2_rr <= r1_rad * r1_rad;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 3: the quadratic coefficients a, b and c, exact.
    // ------------------------------------------------------------------------
    logic                  r3_valid;
    logic signed [AW-1:0]  r3_a;
    logic signed [BW-1:0]  r3_b;
    logic signed [CCW-1:0] r3_c;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a <= AW'(r2_dd[0]) + AW'(r2_dd[1]) + AW'(r2_dd[2]);
            r3_b <= (BW'(r2_od[0]) + BW'(r2_od[1]) + BW'(r2_od[2])) <<< 1;
            r3_c <= CCW'(r2_oo[0]) + CCW'(r2_oo[1]) + CCW'(r2_oo[2]) - CCW'(r2_rr);
        end
    end

    // ------------------------------------------------------------------------
    // Stage 4: partial products of b*b and a*c. Each wide operand is cut into a
    // signed upper half and an unsigned lower half of SPL bits.
    // ------------------------------------------------------------------------
    logic signed [BW-SPL-1:0]  w_bh;
    logic signed [SPL:0]       w_bl;
    logic signed [AW-SPL-1:0]  w_ah;
    logic signed [SPL:0]       w_al;
    logic signed [CCW-SPL-1:0] w_ch;
    logic signed [SPL:0]       w_cl;

    assign w_bh = r3_b[BW-1:SPL];
    assign w_bl = {1'b0, r3_b[SPL-1:0]};
    assign w_ah = r3_a[AW-1:SPL];
    assign w_al = {1'b0, r3_a[SPL-1:0]};
    assign w_ch = r3_c[CCW-1:SPL];
    assign w_cl = {1'b0, r3_c[SPL-1:0]};

    logic                           r4_valid;
    logic                           r4_azero;
    logic signed [AW-1:0]           r4_a;
    logic signed [BW-1:0]           r4_b;
    logic signed [2*(BW-SPL)-1:0]   r4_bhh;
    logic signed [BW:0]             r4_bhl;
    logic        [2*SPL-1:0]        r4_bll;
    logic signed [AW+CCW-2*SPL-1:0] r4_ahch;
    logic signed [AW:0]             r4_ahcl;
    logic signed [CCW:0]            r4_alch;
    logic        [2*SPL-1:0]        r4_alcl;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_azero <= (r3_a == '0);
            r4_a     <= r3_a;
            r4_b     <= r3_b;
            r4_bhh   <= w_bh * w_bh;
            r4_bhl   <= w_bh * w_bl;
            r4_bll   <= r3_b[SPL-1:0] * r3_b[SPL-1:0];
            r4_ahch  <= w_ah * w_ch;
            r4_ahcl  <= w_ah * w_cl;
            r4_alch  <= w_al * w_ch;
            r4_alcl  <= r3_a[SPL-1:0] * r3_c[SPL-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: recombine the partial products into b*b and 4ac.
    // ------------------------------------------------------------------------
    logic                 r5_valid;
    logic                 r5_azero;
    logic signed [AW-1:0] r5_a;
    logic signed [BW-1:0] r5_b;
    logic signed [DW-1:0] r5_bb;
    logic signed [DW-1:0] r5_ac4;
    logic signed [DW-1:0] n5_bb;
    logic signed [DW-1:0] n5_ac4;

    always_comb begin
        logic signed [DW-1:0] t_hh;
        logic signed [DW-1:0] t_hl;
        logic signed [DW-1:0] t_ll;
        logic signed [DW-1:0] t_hc;
        logic signed [DW-1:0] t_hcl;
        logic signed [DW-1:0] t_lch;
        logic signed [DW-1:0] t_lcl;
        t_hh   = r4_bhh;
        t_hl   = r4_bhl;
        t_ll   = r4_bll;
        t_hc   = r4_ahch;
        t_hcl  = r4_ahcl;
        t_lch  = r4_alch;
        t_lcl  = r4_alcl;
        // The cross term of b*b appears twice, hence one extra bit of shift.
        n5_bb  = (t_hh <<< (2 * SPL)) + (t_hl <<< (SPL + 1)) + t_ll;
        n5_ac4 = ((t_hc <<< (2 * SPL)) + ((t_hcl + t_lch) <<< SPL) + t_lcl) <<< 2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_azero <= r4_azero;
            r5_a     <= r4_a;
            r5_b     <= r4_b;
            r5_bb    <= n5_bb;
            r5_ac4   <= n5_ac4;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 6 (square root entry): the discriminant and the item status.
    // A zero-length direction wins over the discriminant test. Items that are
    // not hits feed zero into the root so the later stages carry no garbage.
    // ------------------------------------------------------------------------
    logic                 r_sq_valid  [RW+1];
    logic [STW-1:0]       r_sq_status [RW+1];
    logic [REMW-1:0]      r_sq_rem    [RW+1];
    logic [RW-1:0]        r_sq_root   [RW+1];
    logic [DW-1:0]        r_sq_rad    [RW+1];
    logic signed [AW-1:0] r_sq_a      [RW+1];
    logic signed [BW-1:0] r_sq_b      [RW+1];

    logic signed [DW-1:0] n6_disc;
    logic [STW-1:0]       n6_status;

    always_comb begin
        n6_disc = r5_bb - r5_ac4;
        if (r5_azero) begin
            n6_status = rsi_pkg::ST_DEGEN;
        end else if (n6_disc[DW-1]) begin
            n6_status = rsi_pkg::ST_MISS;
        end else begin
            n6_status = rsi_pkg::ST_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq_status[0] <= n6_status;
            r_sq_rem[0]    <= '0;
            r_sq_root[0]   <= '0;
            r_sq_rad[0]    <= (n6_status == rsi_pkg::ST_HIT) ? n6_disc : '0;
            r_sq_a[0]      <= r5_a;
            r_sq_b[0]      <= r5_b;
        end
    end

    // ------------------------------------------------------------------------
    // Square root: digit recurrence, one root bit per stage. Each stage brings
    // down the next two radicand bits and tries to subtract 4*root + 1.
    // ------------------------------------------------------------------------
    for (genvar j = 0; j < RW; j++) begin : g_sq
        logic [REMW-1:0] n_remsh;
        logic [REMW-1:0] n_trial;
        logic            n_ge;

        always_comb begin
            n_remsh = {r_sq_rem[j][RW:0], r_sq_rad[j][DW-1:DW-2]};
            n_trial = {1'b0, r_sq_root[j], 2'b01};
            n_ge    = (n_remsh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_rem[j+1]    <= n_ge ? (n_remsh - n_trial) : n_remsh;
                r_sq_root[j+1]   <= {r_sq_root[j][RW-2:0], n_ge};
                r_sq_rad[j+1]    <= {r_sq_rad[j][DW-3:0], 2'b00};
                r_sq_status[j+1] <= r_sq_status[j];
                r_sq_a[j+1]      <= r_sq_a[j];
                r_sq_b[j+1]      <= r_sq_b[j];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Numerator stage: (-b - sqrt(disc)) scaled up by the fraction bits.
    // ------------------------------------------------------------------------
    logic                   r_n1_valid;
    logic [STW-1:0]         r_n1_status;
    logic signed [AW-1:0]   r_n1_a;
    logic signed [NUMW-1:0] r_n1_num;
    logic signed [NUMW-1:0] n_n1_num;

    always_comb begin
        logic signed [NUMW-1:0] t_b;
        logic signed [NUMW-1:0] t_s;
        t_b      = r_sq_b[RW];
        t_s      = {1'b0, r_sq_root[RW]};
        n_n1_num = ((-t_b) - t_s) <<< rsi_pkg::FB;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1_status <= r_sq_status[RW];
            r_n1_a      <= r_sq_a[RW];
            r_n1_num    <= n_n1_num;
        end
    end

    // ------------------------------------------------------------------------
    // Sign and magnitude stage: the divider works on magnitudes, and the
    // denominator 2a is positive whenever the item is a hit.
    // ------------------------------------------------------------------------
    logic              r_n2_valid;
    logic [STW-1:0]    r_n2_status;
    logic              r_n2_neg;
    logic [NUMW-1:0]   r_n2_mag;
    logic [DENW-1:0]   r_n2_den;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n2_status <= r_n1_status;
            r_n2_neg    <= r_n1_num[NUMW-1];
            r_n2_mag    <= r_n1_num[NUMW-1] ? (NUMW'(0) - r_n1_num) : r_n1_num;
            r_n2_den    <= {r_n1_a, 1'b0};
        end
    end

    // ------------------------------------------------------------------------
    // Divider entry: a quotient that needs more than QW bits saturates anyway,
    // so that case is flagged here and the divider only produces QW bits.
    // ------------------------------------------------------------------------
    logic              r_dv_valid  [QW+1];
    logic [STW-1:0]    r_dv_status [QW+1];
    logic              r_dv_neg    [QW+1];
    logic              r_dv_ovf    [QW+1];
    logic [DIVW-1:0]   r_dv_rem    [QW+1];
    logic [DENW-1:0]   r_dv_den    [QW+1];
    logic [QW-1:0]     r_dv_q      [QW+1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_status[0] <= r_n2_status;
            r_dv_neg[0]    <= r_n2_neg;
            r_dv_ovf[0]    <= (DIVW'(r_n2_mag) >= (DIVW'(r_n2_den) << QW));
            r_dv_rem[0]    <= DIVW'(r_n2_mag);
            r_dv_den[0]    <= r_n2_den;
            r_dv_q[0]      <= '0;
        end
    end

    // Restoring division, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < QW; k++) begin : g_dv
        localparam int SH = QW - 1 - k;

        logic [DIVW-1:0] n_dsh;
        logic            n_ge;

        always_comb begin
            n_dsh = DIVW'(r_dv_den[k]) << SH;
            n_ge  = (r_dv_rem[k] >= n_dsh);
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[k+1]    <= n_ge ? (r_dv_rem[k] - n_dsh) : r_dv_rem[k];
                r_dv_q[k+1]      <= {r_dv_q[k][QW-2:0], n_ge};
                r_dv_den[k+1]    <= r_dv_den[k];
                r_dv_status[k+1] <= r_dv_status[k];
                r_dv_neg[k+1]    <= r_dv_neg[k];
                r_dv_ovf[k+1]    <= r_dv_ovf[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register: saturate, restore the sign, and clear the distance of
    // misses and degenerate rays.
    // ------------------------------------------------------------------------
    logic                 r_out_valid;
    logic [STW-1:0]       r_out_status;
    logic signed [CW-1:0] r_out_dist;
    logic signed [CW-1:0] n_out_dist;

    always_comb begin
        logic [QW-1:0] t_q;
        logic [QW-1:0] t_negq;
        t_q    = r_dv_q[QW];
        t_negq = QW'(0) - t_q;
        if (r_dv_status[QW] != rsi_pkg::ST_HIT) begin
            n_out_dist = '0;
        end else if (!r_dv_neg[QW]) begin
            if (r_dv_ovf[QW] || t_q > rsi_pkg::Q_MAXPOS) begin
                n_out_dist = rsi_pkg::Q_MAXPOS[CW-1:0];
            end else begin
                n_out_dist = t_q[CW-1:0];
            end
        end else begin
            if (r_dv_ovf[QW] || t_q > rsi_pkg::Q_MINMAG) begin
                n_out_dist = rsi_pkg::Q_MINMAG[CW-1:0];
            end else begin
                n_out_dist = t_negq[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_status <= r_dv_status[QW];
            r_out_dist   <= n_out_dist;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_hit_distance = r_out_dist;

    // ------------------------------------------------------------------------
    // Valid bits: the only state that reset clears.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_valid      <= 1'b0;
            r4_valid      <= 1'b0;
            r5_valid      <= 1'b0;
            r_sq_valid[0] <= 1'b0;
            r_n1_valid    <= 1'b0;
            r_n2_valid    <= 1'b0;
            r_dv_valid[0] <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (w_en) begin
            r1_valid      <= i_in_valid;
            r2_valid      <= r1_valid;
            r3_valid      <= r2_valid;
            r4_valid      <= r3_valid;
            r5_valid      <= r4_valid;
            r_sq_valid[0] <= r5_valid;
            r_n1_valid    <= r_sq_valid[RW];
            r_n2_valid    <= r_n1_valid;
            r_dv_valid[0] <= r_n2_valid;
            r_out_valid   <= r_dv_valid[QW];
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sq_valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[j+1] <= 1'b0;
            end else if (w_en) begin
                r_sq_valid[j+1] <= r_sq_valid[j];
            end
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_dv_valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else if (w_en) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `RSI_ASSERT_IMP(a_nonhit_zero_dist, r_out_valid && r_out_status != rsi_pkg::ST_HIT, r_out_dist == '0, "non-hit item leaves with a nonzero distance")
    `RSI_ASSERT_IMP(a_sqrt_rem_bound, r_sq_valid[RW] && r_sq_status[RW] == rsi_pkg::ST_HIT, r_sq_rem[RW] <= {r_sq_root[RW], 1'b0}, "square root remainder exceeds twice the root")
    `RSI_ASSERT_IMP(a_div_rem_bound, r_dv_valid[QW] && r_dv_status[QW] == rsi_pkg::ST_HIT && !r_dv_ovf[QW], r_dv_rem[QW] < DIVW'(r_dv_den[QW]), "divider remainder not below the denominator")
    `RSI_ASSERT_NEXT(a_sqrt_to_num, w_en && r_sq_valid[RW], r_n1_valid, "item lost between square root and numerator stage")

endmodule
